// File: hdl/itr_pkg.sv
package itr_pkg;

   localparam logic [11:0] MAX_VALUE = 12'd3999;

   // Decimal places, most significant first
   localparam logic [1:0] PLACE_THOU = 2'd0;
   localparam logic [1:0] PLACE_HUND = 2'd1;
   localparam logic [1:0] PLACE_TENS = 2'd2;
   localparam logic [1:0] PLACE_UNIT = 2'd3;

   // Letter roles within one decimal place
   localparam logic [1:0] SYM_NONE = 2'd0;
   localparam logic [1:0] SYM_ONE  = 2'd1;
   localparam logic [1:0] SYM_FIVE = 2'd2;
   localparam logic [1:0] SYM_TEN  = 2'd3;

   localparam logic [7:0] CH_M = 8'h4D;
   localparam logic [7:0] CH_D = 8'h44;
   localparam logic [7:0] CH_C = 8'h43;
   localparam logic [7:0] CH_L = 8'h4C;
   localparam logic [7:0] CH_X = 8'h58;
   localparam logic [7:0] CH_V = 8'h56;
   localparam logic [7:0] CH_I = 8'h49;

   typedef logic [1:0] place_type;

   typedef struct packed {
      logic [1:0] thousands;
      logic [3:0] hundreds;
      logic [3:0] tens;
      logic [3:0] units;
   } digits_type;

   typedef struct packed {
      logic      found;
      place_type idx;
   } place_hit_type;

   // Weight of the digit resolved at each conversion step
   function automatic logic [11:0] place_unit(input logic [1:0] step);
      logic [11:0] unit;
      unique case (step)
         2'd0:    unit = 12'd1000;
         2'd1:    unit = 12'd100;
         2'd2:    unit = 12'd10;
         default: unit = 12'd1;
      endcase
      return unit;
   endfunction

   // Number of letters in one digit's group
   function automatic logic [2:0] pattern_length(input logic [3:0] d);
      logic [2:0] len;
      unique case (d)
         4'd1, 4'd5:       len = 3'd1;
         4'd2, 4'd4, 4'd6,
         4'd9:             len = 3'd2;
         4'd3, 4'd7:       len = 3'd3;
         4'd8:             len = 3'd4;
         default:          len = 3'd0;
      endcase
      return len;
   endfunction

   // Role of letter k within one digit's group
   function automatic logic [1:0] pattern_symbol(input logic [3:0] d, input logic [1:0] k);
      logic [1:0] sym;
      sym = SYM_NONE;
      unique case (d)
         4'd1, 4'd2, 4'd3: sym = SYM_ONE;
         4'd4:             sym = (k == 2'd0) ? SYM_ONE : SYM_FIVE;
         4'd5, 4'd6,
         4'd7, 4'd8:       sym = (k == 2'd0) ? SYM_FIVE : SYM_ONE;
         4'd9:             sym = (k == 2'd0) ? SYM_ONE : SYM_TEN;
         default:          sym = SYM_NONE;
      endcase
      return sym;
   endfunction

   function automatic logic [7:0] place_letter(input place_type place, input logic [1:0] sym);
      logic [7:0] ch;
      ch = CH_I;
      unique case (place)
         PLACE_THOU: ch = CH_M;
         PLACE_HUND: ch = (sym == SYM_ONE) ? CH_C : (sym == SYM_FIVE) ? CH_D : CH_M;
         PLACE_TENS: ch = (sym == SYM_ONE) ? CH_X : (sym == SYM_FIVE) ? CH_L : CH_C;
         default:    ch = (sym == SYM_ONE) ? CH_I : (sym == SYM_FIVE) ? CH_V : CH_X;
      endcase
      return ch;
   endfunction

   // Lowest-numbered (most significant) place whose bit is set
   function automatic place_hit_type find_place(input logic [3:0] present);
      place_hit_type hit;
      hit = '0;
      for (int p = 3; p >= 0; p--) begin
         if (present[p]) begin
            hit.found = 1'b1;
            hit.idx   = 2'(p);
         end
      end
      return hit;
   endfunction

endpackage

// File: hdl/itr_front.sv
module itr_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [11:0]         req_value,
   output logic                push_valid,
   output itr_pkg::digits_type push_data,
   input  logic                queue_full
);

   localparam logic [1:0] FS_IDLE = 2'd0;
   localparam logic [1:0] FS_CONV = 2'd1;
   localparam logic [1:0] FS_PUSH = 2'd2;

   logic [1:0]          state_ff, state_in;
   logic [1:0]          step_ff, step_in;
   logic [11:0]         rem_ff, rem_in;
   itr_pkg::digits_type digits_ff, digits_in;

   logic [11:0] unit;
   logic [3:0]  digit;
   logic [11:0] taken;
   logic [13:0] threshold;
   logic        nonzero;

   // One decimal digit a step: compare the remainder against its nine multiples
   always_comb begin
      unit  = itr_pkg::place_unit(step_ff);
      digit = 4'd0;
      taken = 12'd0;
      threshold = 14'd0;
      for (int d = 1; d <= 9; d++) begin
         threshold = 14'(d) * {2'b00, unit};
         if ({2'b00, rem_ff} >= threshold) begin
            digit = 4'(d);
            taken = threshold[11:0];
         end
      end
   end

   assign nonzero    = (digits_ff != '0);
   assign req_ready  = (state_ff == FS_IDLE);
   assign push_valid = (state_ff == FS_PUSH) && nonzero;
   assign push_data  = digits_ff;

   always_comb begin
      state_in  = state_ff;
      step_in   = step_ff;
      rem_in    = rem_ff;
      digits_in = digits_ff;
      unique case (state_ff)
         FS_IDLE: begin
            if (req_valid) begin
               rem_in   = (req_value > itr_pkg::MAX_VALUE) ? itr_pkg::MAX_VALUE : req_value;
               step_in  = 2'd0;
               state_in = FS_CONV;
            end
         end
         FS_CONV: begin
            rem_in = rem_ff - taken;
            unique case (step_ff)
               2'd0:    digits_in.thousands = digit[1:0];
               2'd1:    digits_in.hundreds  = digit;
               default: begin
                  digits_in.tens  = digit;
                  digits_in.units = rem_in[3:0];
               end
            endcase
            step_in = step_ff + 2'd1;
            if (step_ff == 2'd2) begin
               state_in = FS_PUSH;
            end
         end
         FS_PUSH: begin
            // drop a zero outright, it has no letters
            if (!nonzero || !queue_full) begin
               state_in = FS_IDLE;
            end
         end
         default: state_in = FS_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FS_IDLE;
         step_ff  <= 2'd0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
      rem_ff    <= rem_in;
      digits_ff <= digits_in;
   end

endmodule

// File: hdl/itr_queue.sv
module itr_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   input  itr_pkg::digits_type push_data,
   output logic                full,
   input  logic                pop,
   output logic                pop_valid,
   output itr_pkg::digits_type pop_data
);

   itr_pkg::digits_type entry_ff [2];
   logic                wr_ptr_ff, wr_ptr_in;
   logic                rd_ptr_ff, rd_ptr_in;
   logic [1:0]          count_ff, count_in;
   logic                do_push, do_pop;

   assign full      = (count_ff == 2'd2);
   assign pop_valid = (count_ff != 2'd0);
   assign pop_data  = entry_ff[rd_ptr_ff];
   assign do_push   = push_valid && !full;
   assign do_pop    = pop && pop_valid;

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: hdl/itr_back.sv
module itr_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                pop_valid,
   input  itr_pkg::digits_type pop_data,
   output logic                pop,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [7:0]          rsp_letter,
   output logic                rsp_last
);

   itr_pkg::digits_type entry_ff, entry_in;
   logic                busy_ff, busy_in;
   itr_pkg::place_type  place_ff, place_in;
   logic [1:0]          k_ff, k_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [7:0]          rsp_letter_ff, rsp_letter_in;
   logic                rsp_last_ff, rsp_last_in;

   logic [2:0]            lens [4];
   logic [3:0]            cur_digit;
   logic [1:0]            sym;
   logic [7:0]            letter;
   logic                  more_here;
   logic [3:0]            later;
   logic [3:0]            first_mask;
   itr_pkg::place_hit_type next_hit;
   itr_pkg::place_hit_type first_hit;
   logic                  is_last;
   logic                  emit;

   always_comb begin
      lens[0] = {1'b0, entry_ff.thousands};
      lens[1] = itr_pkg::pattern_length(entry_ff.hundreds);
      lens[2] = itr_pkg::pattern_length(entry_ff.tens);
      lens[3] = itr_pkg::pattern_length(entry_ff.units);

      unique case (place_ff)
         itr_pkg::PLACE_THOU: cur_digit = {2'b00, entry_ff.thousands};
         itr_pkg::PLACE_HUND: cur_digit = entry_ff.hundreds;
         itr_pkg::PLACE_TENS: cur_digit = entry_ff.tens;
         default:             cur_digit = entry_ff.units;
      endcase

      sym = (place_ff == itr_pkg::PLACE_THOU) ? itr_pkg::SYM_ONE
                                              : itr_pkg::pattern_symbol(cur_digit, k_ff);
      letter    = itr_pkg::place_letter(place_ff, sym);
      more_here = (({1'b0, k_ff} + 3'd1) < lens[place_ff]);

      for (int p = 0; p < 4; p++) begin
         later[p] = (lens[p] != 3'd0) && (2'(p) > place_ff);
      end
      next_hit = itr_pkg::find_place(later);
      is_last  = !more_here && !next_hit.found;

      first_mask = {pop_data.units != 4'd0, pop_data.tens != 4'd0,
                    pop_data.hundreds != 4'd0, pop_data.thousands != 2'd0};
      first_hit  = itr_pkg::find_place(first_mask);
   end

   assign emit = busy_ff && (!rsp_valid_ff || rsp_ready);
   assign pop  = !busy_ff && pop_valid;

   always_comb begin
      entry_in      = entry_ff;
      busy_in       = busy_ff;
      place_in      = place_ff;
      k_in          = k_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_letter_in = rsp_letter_ff;
      rsp_last_in   = rsp_last_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      if (pop) begin
         entry_in = pop_data;
         busy_in  = 1'b1;
         place_in = first_hit.idx;
         k_in     = 2'd0;
      end else if (emit) begin
         rsp_valid_in  = 1'b1;
         rsp_letter_in = letter;
         rsp_last_in   = is_last;
         // advance within the digit, else move to the next place that has letters
         if (more_here) begin
            k_in = k_ff + 2'd1;
         end else begin
            place_in = next_hit.idx;
            k_in     = 2'd0;
         end
         if (is_last) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      entry_ff      <= entry_in;
      place_ff      <= place_in;
      k_ff          <= k_in;
      rsp_letter_ff <= rsp_letter_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_letter = rsp_letter_ff;
   assign rsp_last   = rsp_last_ff;

endmodule

// File: hdl/integer_to_roman_numeral.sv
// A request passes through the converter, a two-entry queue and the letter walker,
// whose output register gives one letter per cycle while rsp_ready does not stall it;
// the walker loads each numeral from the queue before its first letter. The converter
// takes no new request until the last one is pushed, and runs ahead through the queue.
// Reset is synchronous, active high: empties the queue and drops any work in flight.
module integer_to_roman_numeral (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [11:0] req_value,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_letter,
   output logic        rsp_last
);

   logic                push_valid;
   itr_pkg::digits_type push_data;
   logic                queue_full;
   logic                pop;
   logic                pop_valid;
   itr_pkg::digits_type pop_data;

   itr_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_value  (req_value),
      .push_valid (push_valid),
      .push_data  (push_data),
      .queue_full (queue_full)
   );

   itr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .full       (queue_full),
      .pop        (pop),
      .pop_valid  (pop_valid),
      .pop_data   (pop_data)
   );

   itr_back u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop_data   (pop_data),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_letter (rsp_letter),
      .rsp_last   (rsp_last)
   );

endmodule

// File: hdl/itr_checker.sv
module itr_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [7:0]  rsp_letter,
   input logic        rsp_last
);

   logic [3:0] run_ff, run_in;

   // count letters already delivered for the numeral in progress
   always_comb begin
      run_in = run_ff;
      if (rsp_valid && rsp_ready) begin
         run_in = rsp_last ? 4'd0 : run_ff + 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 4'd0;
      end else begin
         run_ff <= run_in;
      end
   end

   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_letter) && $stable(rsp_last))
      else $error("stalled result changed");

   a_letter_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_letter == itr_pkg::CH_M || rsp_letter == itr_pkg::CH_D ||
                     rsp_letter == itr_pkg::CH_C || rsp_letter == itr_pkg::CH_L ||
                     rsp_letter == itr_pkg::CH_X || rsp_letter == itr_pkg::CH_V ||
                     rsp_letter == itr_pkg::CH_I))
      else $error("letter is not a numeral letter");

   a_max_length: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && run_ff == 4'd14 |-> rsp_last)
      else $error("numeral longer than fifteen letters");

endmodule

bind integer_to_roman_numeral itr_checker u_itr_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_valid  (rsp_valid),
   .rsp_ready  (rsp_ready),
   .rsp_letter (rsp_letter),
   .rsp_last   (rsp_last)
);
